// ----- design/nnfu_pkg.sv -----
// ----------------------------------------------------------------------------
// nnfu_pkg
// Shared types and codes of the nearest-neighbor frame upscaler.
// ----------------------------------------------------------------------------
package nnfu_pkg;

   // request word: pixel write or scaled pixel read
   typedef struct packed {
      logic       func;
      logic [7:0] src_x;
      logic [7:0] src_y;
      logic [15:0] pixel_in;
      logic [8:0] out_x;
      logic [7:0] out_y;
   } nnfu_req_type;

   // response word: one per read
   typedef struct packed {
      logic [15:0] pixel_out;
      logic        out_of_range;
   } nnfu_rsp_type;

   typedef logic [1:0] nnfu_mode_type;

   // func codes
   localparam logic FUNC_WRITE = 1'b0;
   localparam logic FUNC_READ  = 1'b1;

   // output size select codes (the unused code behaves as fit)
   localparam nnfu_mode_type MODE_1X   = 2'd0;
   localparam nnfu_mode_type MODE_FIT  = 2'd1;
   localparam nnfu_mode_type MODE_FULL = 2'd2;

   localparam nnfu_mode_type MODE_RESET = MODE_FIT;

   // fixed output sizes
   localparam int unsigned FIT_W  = 240;
   localparam int unsigned FIT_H  = 216;
   localparam int unsigned FULL_W = 320;
   localparam int unsigned FULL_H = 240;

endpackage

// ----- design/nnfu_ram.sv -----
// ----------------------------------------------------------------------------
// nnfu_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module nnfu_ram #(
   parameter int unsigned WIDTH = 16,
   parameter int unsigned DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      // read data holds while rd_en is low
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/nnfu_div.sv -----
// ----------------------------------------------------------------------------
// nnfu_div
// Coordinate scaling lane: registered multiply by a constant reciprocal.
// ----------------------------------------------------------------------------
module nnfu_div #(
   parameter int unsigned COORD_W = 9,
   parameter int unsigned RECIP_W = 19,
   parameter int unsigned SHIFT   = 18,
   parameter int unsigned QUO_W   = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [COORD_W-1:0] coord,
   input  logic [RECIP_W-1:0] recip,
   output logic               done,
   output logic [QUO_W-1:0]   quot
);

   localparam int unsigned PW = COORD_W + RECIP_W;

   logic [PW-1:0] prod_ff, prod_in;
   logic          done_ff, done_in;

   // product captured with the request; the quotient is its upper bits
   assign prod_in = start ? (PW'(coord) * PW'(recip)) : prod_ff;
   assign done_in = start;

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff <= 1'b0;
      end else begin
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign done = done_ff;
   assign quot = QUO_W'(prod_ff >> SHIFT);

endmodule

// ----- design/nearest_neighbor_frame_upscaler_unit.sv -----
// ----------------------------------------------------------------------------
// nearest_neighbor_frame_upscaler_unit
// Source frame store with nearest-neighbor scaled read-out.
// ----------------------------------------------------------------------------
// Holds one SRC_WIDTH x SRC_HEIGHT RGB565 frame in a single-port-write RAM.
// A write word (func = write) stores pixel_in at (src_x, src_y) and gives no
// response; coordinates outside the frame are dropped. A read word names an
// output pixel (out_x, out_y) and returns the source pixel at column
// out_x*SRC_WIDTH/W and row out_y*SRC_HEIGHT/H, floored, where W x H is the
// output size picked by the size select register (1x, fit 240x216, full
// 320x240; the unused code acts as fit; sizes clamp at OUT_WIDTH_MAX /
// OUT_HEIGHT_MAX). A read beyond W x H returns zero with out_of_range set.
// Timing: writes can follow back to back. An out-of-range read holds the
// input through accept and response load. An in-range read holds it
// through accept, RAM read and response load: the source column and row
// come from a multiply by a per-mode constant reciprocal in the accept
// cycle, the RAM read takes the next cycle, then the response register loads.
// Words are taken one at a time; the response register lets the next
// request in while a response waits, but a read then stalls in its load
// step until the consumer takes the older word.
// The store has no reset: read only pixels that were written. The size
// select resets to fit; the user must write it through csr_* only while
// the unit is idle, as the unit itself does not enforce this.
// ----------------------------------------------------------------------------
module nearest_neighbor_frame_upscaler_unit #(
   parameter int unsigned SRC_WIDTH      = 160,
   parameter int unsigned SRC_HEIGHT     = 144,
   parameter int unsigned OUT_WIDTH_MAX  = 320,
   parameter int unsigned OUT_HEIGHT_MAX = 240
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  nnfu_pkg::nnfu_req_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output nnfu_pkg::nnfu_rsp_type rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  nnfu_pkg::nnfu_mode_type csr_data
);

   import nnfu_pkg::*;

   // ceil(num * 2**shift / den), evaluated at elaboration
   function automatic longint unsigned ceil_recip(input int unsigned num,
                                                  input int unsigned den,
                                                  input int unsigned shift);
      return ((64'(num) << shift) + 64'(den) - 64'd1) / 64'(den);
   endfunction

   function automatic longint unsigned max3(input longint unsigned a,
                                            input longint unsigned b,
                                            input longint unsigned c);
      longint unsigned m;
      m = (a > b) ? a : b;
      return (m > c) ? m : c;
   endfunction

   // output sizes per mode, clamped
   localparam int unsigned W_1X   = (SRC_WIDTH  > OUT_WIDTH_MAX)  ? OUT_WIDTH_MAX  : SRC_WIDTH;
   localparam int unsigned H_1X   = (SRC_HEIGHT > OUT_HEIGHT_MAX) ? OUT_HEIGHT_MAX : SRC_HEIGHT;
   localparam int unsigned W_FIT  = (FIT_W  > OUT_WIDTH_MAX)  ? OUT_WIDTH_MAX  : FIT_W;
   localparam int unsigned H_FIT  = (FIT_H  > OUT_HEIGHT_MAX) ? OUT_HEIGHT_MAX : FIT_H;
   localparam int unsigned W_FULL = (FULL_W > OUT_WIDTH_MAX)  ? OUT_WIDTH_MAX  : FULL_W;
   localparam int unsigned H_FULL = (FULL_H > OUT_HEIGHT_MAX) ? OUT_HEIGHT_MAX : FULL_H;

   localparam int unsigned WW  = $clog2(OUT_WIDTH_MAX + 1);
   localparam int unsigned HW  = $clog2(OUT_HEIGHT_MAX + 1);
   localparam int unsigned CXW = (WW > 9) ? WW : 9;   // compare width vs out_x
   localparam int unsigned CYW = (HW > 8) ? HW : 8;   // compare width vs out_y

   // sx = (out_x * RX) >> SX with RX = ceil(SRC_WIDTH * 2**SX / W); exact for
   // every out_x < W since 2**SX >= W * W keeps the rounding error below 1/W.
   // Same scheme for rows.
   localparam int unsigned SX = 2 * WW;
   localparam int unsigned SY = 2 * HW;

   localparam longint unsigned RX_1X   = ceil_recip(SRC_WIDTH, W_1X, SX);
   localparam longint unsigned RX_FIT  = ceil_recip(SRC_WIDTH, W_FIT, SX);
   localparam longint unsigned RX_FULL = ceil_recip(SRC_WIDTH, W_FULL, SX);
   localparam longint unsigned RY_1X   = ceil_recip(SRC_HEIGHT, H_1X, SY);
   localparam longint unsigned RY_FIT  = ceil_recip(SRC_HEIGHT, H_FIT, SY);
   localparam longint unsigned RY_FULL = ceil_recip(SRC_HEIGHT, H_FULL, SY);

   localparam int unsigned RXW = $clog2(max3(RX_1X, RX_FIT, RX_FULL) + 64'd1);
   localparam int unsigned RYW = $clog2(max3(RY_1X, RY_FIT, RY_FULL) + 64'd1);

   localparam int unsigned QXW  = $clog2(SRC_WIDTH);
   localparam int unsigned QYW  = $clog2(SRC_HEIGHT);

   localparam int unsigned DEPTH = SRC_WIDTH * SRC_HEIGHT;
   localparam int unsigned AW    = $clog2(DEPTH);

   // sequencer
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DIV  = 2'd1;
   localparam logic [1:0] ST_LOAD = 2'd2;

   logic [1:0]    state_ff, state_in;
   nnfu_mode_type mode_ff, mode_in;
   logic          oor_ff, oor_in;
   logic          rsp_valid_ff, rsp_valid_in;
   nnfu_rsp_type  rsp_data_ff, rsp_data_in;

   logic [WW-1:0]  cur_w;
   logic [HW-1:0]  cur_h;
   logic [RXW-1:0] rec_x;
   logic [RYW-1:0] rec_y;
   logic           req_fire, rd_fire, wr_fire, in_range;
   logic           div_start, done_x, done_y;
   logic [QXW-1:0] quot_x;
   logic [QYW-1:0] quot_y;
   logic           ram_we, ram_re;
   logic [AW-1:0]  ram_waddr, ram_raddr;
   logic [15:0]    ram_rdata;

   // -------------------------------------------------------------------------
   // configuration
   // -------------------------------------------------------------------------
   assign csr_ready = 1'b1;
   assign mode_in   = (csr_valid && csr_ready) ? csr_data : mode_ff;

   always_comb begin
      unique case (mode_ff)
         MODE_1X: begin
            cur_w = WW'(W_1X);
            cur_h = HW'(H_1X);
            rec_x = RXW'(RX_1X);
            rec_y = RYW'(RY_1X);
         end
         MODE_FULL: begin
            cur_w = WW'(W_FULL);
            cur_h = HW'(H_FULL);
            rec_x = RXW'(RX_FULL);
            rec_y = RYW'(RY_FULL);
         end
         default: begin
            cur_w = WW'(W_FIT);
            cur_h = HW'(H_FIT);
            rec_x = RXW'(RX_FIT);
            rec_y = RYW'(RY_FIT);
         end
      endcase
   end

   // -------------------------------------------------------------------------
   // request decode
   // -------------------------------------------------------------------------
   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign rd_fire   = req_fire && (req_data.func == FUNC_READ);
   assign wr_fire   = req_fire && (req_data.func == FUNC_WRITE);

   assign in_range = (CXW'(req_data.out_x) < CXW'(cur_w))
                  && (CYW'(req_data.out_y) < CYW'(cur_h));

   assign div_start = rd_fire && in_range;

   // pixel write goes straight into the store
   assign ram_we    = wr_fire
                   && (32'(req_data.src_x) < SRC_WIDTH)
                   && (32'(req_data.src_y) < SRC_HEIGHT);
   assign ram_waddr = AW'(32'(req_data.src_y) * 32'(SRC_WIDTH) + 32'(req_data.src_x));

   // -------------------------------------------------------------------------
   // coordinate scaling
   // -------------------------------------------------------------------------
   nnfu_div #(
      .COORD_W (9),
      .RECIP_W (RXW),
      .SHIFT   (SX),
      .QUO_W   (QXW)
   ) u_div_x (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .coord (req_data.out_x),
      .recip (rec_x),
      .done  (done_x),
      .quot  (quot_x)
   );

   nnfu_div #(
      .COORD_W (8),
      .RECIP_W (RYW),
      .SHIFT   (SY),
      .QUO_W   (QYW)
   ) u_div_y (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .coord (req_data.out_y),
      .recip (rec_y),
      .done  (done_y),
      .quot  (quot_y)
   );

   // -------------------------------------------------------------------------
   // frame store
   // -------------------------------------------------------------------------
   assign ram_re    = (state_ff == ST_DIV) && done_x && done_y;
   assign ram_raddr = AW'(32'(quot_y) * 32'(SRC_WIDTH) + 32'(quot_x));

   nnfu_ram #(
      .WIDTH (16),
      .DEPTH (DEPTH)
   ) u_frame (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (req_data.pixel_in),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // -------------------------------------------------------------------------
   // sequencer and response register
   // -------------------------------------------------------------------------
   always_comb begin
      state_in     = state_ff;
      oor_in       = oor_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      // consumer took the pending word
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (rd_fire) begin
               oor_in   = !in_range;
               state_in = in_range ? ST_DIV : ST_LOAD;
            end
         end
         ST_DIV: begin
            if (ram_re) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            // wait for a free response slot; RAM data holds meanwhile
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in             = 1'b1;
               rsp_data_in.out_of_range = oor_ff;
               rsp_data_in.pixel_out    = oor_ff ? 16'h0000 : ram_rdata;
               state_in                 = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mode_ff      <= MODE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      oor_ff      <= oor_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ----- design/nnfu_checker.sv -----
// ----------------------------------------------------------------------------
// nnfu_checker
// Port-level assertions for the frame upscaler, bound to the top level.
// ----------------------------------------------------------------------------
module nnfu_checker (
   input logic                    clock,
   input logic                    reset,
   input logic                    req_valid,
   input logic                    req_ready,
   input nnfu_pkg::nnfu_req_type  req_data,
   input logic                    rsp_valid,
   input logic                    rsp_ready,
   input nnfu_pkg::nnfu_rsp_type  rsp_data,
   input logic                    csr_valid,
   input logic                    csr_ready
);

   import nnfu_pkg::*;

   // out-of-range responses carry a zero pixel
   a_oor_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.out_of_range |-> rsp_data.pixel_out == 16'h0000)
      else $error("out-of-range response with nonzero pixel");

   // a read occupies the unit: no new request next cycle
   a_read_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_data.func == FUNC_READ |=> !req_ready)
      else $error("request taken right after a read");

   // a write never produces a response
   a_write_silent: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_data.func == FUNC_WRITE && !rsp_valid |=> !rsp_valid)
      else $error("response appeared after a write");

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response dropped or changed");

   // configuration port is always open
   a_csr_open: assert property (@(posedge clock) disable iff (reset)
      csr_valid |-> csr_ready)
      else $error("configuration write stalled");

endmodule

bind nearest_neighbor_frame_upscaler_unit nnfu_checker u_nnfu_checker (.*);
